@@ sv/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler package
// Shared sizes, opcodes, table entry types and small helper functions.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Table and time sizing.
  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int FIELD_W   = 16;
  localparam int URG_W     = 8;
  localparam int CFG_W     = 5;
  localparam int FIN_W     = 5;

  // Item opcodes.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Static part of a task entry, held in one memory word.
  typedef struct packed {
    logic [FIELD_W-1:0] burst;
    logic [FIELD_W-1:0] arrival;
    logic [URG_W-1:0]   urgency;
  } pps_entry_t;

  // One candidate of the scan: a sampled entry or the running winner.
  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   idx;
    pps_entry_t         entry;
    logic [FIELD_W-1:0] rem;
  } pps_cand_t;

  // Clamp a wide unsigned value to the 16-bit field range.
  function automatic logic [FIELD_W-1:0] sat16(input logic [33:0] v);
    logic [FIELD_W-1:0] r;
    if (v > 34'({FIELD_W{1'b1}})) begin
      r = {FIELD_W{1'b1}};
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

  // Number of entries in use: zero acts as one, large values clamp to the table.
  function automatic logic [CNT_W-1:0] tasks_in_use(input logic [CFG_W-1:0] c);
    logic [CNT_W-1:0] r;
    if (c == '0) begin
      r = CNT_W'(1);
    end else if (32'(c) > MAX_TASKS) begin
      r = CNT_W'(MAX_TASKS);
    end else begin
      r = CNT_W'(c);
    end
    return r;
  endfunction

endpackage

@@ sv/pps_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pps_pick.sv @@
// ----------------------------------------------------------------------------
// Scheduler winner tracker
// Compares one sampled entry per cycle against the running winner.
// ----------------------------------------------------------------------------
module pps_pick import pps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  pps_cand_t            smp,
  input  logic [TIME_BITS-1:0] now,
  output pps_cand_t            best
);

  pps_cand_t best_r;
  pps_cand_t best_nxt;
  logic      eligible;
  logic      better;

  // An entry competes once it has arrived and still needs service.
  assign eligible = smp.valid && (32'(smp.entry.arrival) <= 32'(now)) && (smp.rem != '0);

  // Smaller urgency wins, then smaller remaining count; equal keeps the lower index.
  assign better = !best_r.valid
               || (smp.entry.urgency < best_r.entry.urgency)
               || ((smp.entry.urgency == best_r.entry.urgency) && (smp.rem < best_r.rem));

  always_comb begin
    best_nxt = best_r;
    if (clear) begin
      best_nxt.valid = 1'b0;
    end else if (eligible && better) begin
      best_nxt = smp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r.valid <= 1'b0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign best = best_r;

endmodule

@@ sv/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// Preemptive priority scheduler
// Task table in two memories; each tick scans the entries in use, serves the
// winner and reports waiting and turnaround times when it finishes.
// ----------------------------------------------------------------------------
//
// Channel   Handshake             Payload
// input     start / busy          in_opcode, in_slot, in_burst, in_arrival, in_urgency
// result    out_valid (strobe)    out_ran .. out_all_done, one item per input item
// config    cfg_we                cfg_data (task count)
//
// A tick reads each of the entries in use from the table, then updates the
// winner's remaining count, presents a result and returns to idle. A restart
// rewrites the remaining count of every table entry from its burst (one
// remaining count rewritten per cycle); a load, an undefined item and a
// tick after all tasks are done go straight to the result.
// Reset is synchronous and active low; the table memories are not cleared.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit import pps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_slot,
  input  logic [FIELD_W-1:0] in_burst,
  input  logic [FIELD_W-1:0] in_arrival,
  input  logic [URG_W-1:0]   in_urgency,
  output logic               out_valid,
  output logic               out_ran,
  output logic [3:0]         out_task_index,
  output logic [FIELD_W-1:0] out_tick_time,
  output logic               out_finished,
  output logic [FIELD_W-1:0] out_waiting_time,
  output logic [FIELD_W-1:0] out_turnaround_time,
  output logic               out_all_done,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_RESULT = 3'd4;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [FIN_W-1:0]     FIN_MAX  = {FIN_W{1'b1}};

  logic [2:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [FIN_W-1:0]     fin_r, fin_nxt;
  logic [CFG_W-1:0]     task_count_r, task_count_nxt;

  logic                 res_ran_r, res_ran_nxt;
  logic [IDX_W-1:0]     res_idx_r, res_idx_nxt;
  logic [FIELD_W-1:0]   res_time_r, res_time_nxt;
  logic                 res_fin_r, res_fin_nxt;
  logic [FIELD_W-1:0]   res_wait_r, res_wait_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ran_r, out_ran_nxt;
  logic [3:0]           out_idx_r, out_idx_nxt;
  logic [FIELD_W-1:0]   out_time_r, out_time_nxt;
  logic                 out_fin_r, out_fin_nxt;
  logic [FIELD_W-1:0]   out_wait_r, out_wait_nxt;
  logic [FIELD_W-1:0]   out_turn_r, out_turn_nxt;
  logic                 out_done_r, out_done_nxt;

  logic                 accept;
  logic [CNT_W-1:0]     n_use;
  logic                 sched_done;
  logic [IDX_W-1:0]     prev_idx;

  logic                 st_we;
  logic [IDX_W-1:0]     st_waddr;
  pps_entry_t           st_wdata;
  pps_entry_t           st_rdata;
  logic                 rm_we;
  logic [IDX_W-1:0]     rm_waddr;
  logic [FIELD_W-1:0]   rm_wdata;
  logic [FIELD_W-1:0]   rm_rdata;
  logic [IDX_W-1:0]     raddr;

  pps_cand_t            smp;
  pps_cand_t            best;
  logic [FIELD_W-1:0]   rem_dec;
  logic [33:0]          finish_w;
  logic [33:0]          need_w;
  logic [33:0]          wait_w;

  // Handshake and schedule status.
  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign n_use      = tasks_in_use(task_count_r);
  assign sched_done = (32'(fin_r) >= 32'(n_use));
  assign prev_idx   = IDX_W'(cnt_r - CNT_W'(1));
  assign raddr      = cnt_r[IDX_W-1:0];

  // Static fields and remaining counts live in two RAMs sharing a read address.
  pps_ram #(
    .DATA_W ($bits(pps_entry_t)),
    .ADDR_W (IDX_W)
  ) u_static_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  pps_ram #(
    .DATA_W (FIELD_W),
    .ADDR_W (IDX_W)
  ) u_remain_ram (
    .clk   (clk),
    .we    (rm_we),
    .waddr (rm_waddr),
    .wdata (rm_wdata),
    .raddr (raddr),
    .rdata (rm_rdata)
  );

  // Read data of the previous scan address feeds the winner tracker.
  always_comb begin
    smp.valid = (state_r == S_SCAN) && (cnt_r != '0);
    smp.idx   = prev_idx;
    smp.entry = st_rdata;
    smp.rem   = rm_rdata;
  end

  pps_pick u_pick (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (accept),
    .smp   (smp),
    .now   (now_r),
    .best  (best)
  );

  // Completion arithmetic for the served task.
  assign rem_dec  = best.rem - FIELD_W'(1);
  assign finish_w = 34'(now_r) + 34'(1);
  assign need_w   = 34'(best.entry.burst) + 34'(best.entry.arrival);
  assign wait_w   = (finish_w > need_w) ? (finish_w - need_w) : '0;

  // Memory writes: load, restart sweep and the tick update never overlap.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = IDX_W'(in_slot);
    st_wdata = '{burst: in_burst, arrival: in_arrival, urgency: in_urgency};
    rm_we    = 1'b0;
    rm_waddr = IDX_W'(in_slot);
    rm_wdata = in_burst;
    if (accept && (in_opcode == OP_LOAD) && (32'(in_slot) < MAX_TASKS)) begin
      st_we = 1'b1;
      rm_we = 1'b1;
    end else if ((state_r == S_SWEEP) && (cnt_r != '0)) begin
      rm_we    = 1'b1;
      rm_waddr = prev_idx;
      rm_wdata = st_rdata.burst;
    end else if ((state_r == S_UPDATE) && best.valid) begin
      rm_we    = 1'b1;
      rm_waddr = best.idx;
      rm_wdata = rem_dec;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    now_nxt        = now_r;
    fin_nxt        = fin_r;
    task_count_nxt = cfg_we ? cfg_data : task_count_r;
    res_ran_nxt    = res_ran_r;
    res_idx_nxt    = res_idx_r;
    res_time_nxt   = res_time_r;
    res_fin_nxt    = res_fin_r;
    res_wait_nxt   = res_wait_r;
    out_valid_nxt  = 1'b0;
    out_ran_nxt    = out_ran_r;
    out_idx_nxt    = out_idx_r;
    out_time_nxt   = out_time_r;
    out_fin_nxt    = out_fin_r;
    out_wait_nxt   = out_wait_r;
    out_turn_nxt   = out_turn_r;
    out_done_nxt   = out_done_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt      = '0;
          res_ran_nxt  = 1'b0;
          res_idx_nxt  = '0;
          res_time_nxt = '0;
          res_fin_nxt  = 1'b0;
          res_wait_nxt = '0;
          if (in_opcode == OP_TICK) begin
            state_nxt = sched_done ? S_RESULT : S_SCAN;
          end else if (in_opcode == OP_RESTART) begin
            now_nxt   = '0;
            fin_nxt   = '0;
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_SCAN: begin
        // The last sample is compared in the cycle where the count reaches n.
        if (cnt_r == n_use) begin
          state_nxt = S_UPDATE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_UPDATE: begin
        res_time_nxt = FIELD_W'(now_r);
        if (best.valid) begin
          res_ran_nxt = 1'b1;
          res_idx_nxt = best.idx;
          if (rem_dec == '0) begin
            res_fin_nxt  = 1'b1;
            res_wait_nxt = sat16(wait_w);
            if (fin_r != FIN_MAX) begin
              fin_nxt = fin_r + FIN_W'(1);
            end
          end
        end
        if (now_r != TIME_MAX) begin
          now_nxt = now_r + TIME_BITS'(1);
        end
        state_nxt = S_RESULT;
      end
      S_SWEEP: begin
        if (cnt_r == CNT_W'(MAX_TASKS)) begin
          state_nxt = S_RESULT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_RESULT: begin
        out_valid_nxt = 1'b1;
        out_ran_nxt   = res_ran_r;
        out_idx_nxt   = 4'(res_idx_r);
        out_time_nxt  = res_time_r;
        out_fin_nxt   = res_fin_r;
        out_wait_nxt  = res_wait_r;
        out_turn_nxt  = res_fin_r ? sat16(34'(res_wait_r) + 34'(best.entry.burst)) : '0;
        out_done_nxt  = sched_done;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      now_r        <= '0;
      fin_r        <= '0;
      task_count_r <= CFG_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      now_r        <= now_nxt;
      fin_r        <= fin_nxt;
      task_count_r <= task_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    res_ran_r  <= res_ran_nxt;
    res_idx_r  <= res_idx_nxt;
    res_time_r <= res_time_nxt;
    res_fin_r  <= res_fin_nxt;
    res_wait_r <= res_wait_nxt;
    out_ran_r  <= out_ran_nxt;
    out_idx_r  <= out_idx_nxt;
    out_time_r <= out_time_nxt;
    out_fin_r  <= out_fin_nxt;
    out_wait_r <= out_wait_nxt;
    out_turn_r <= out_turn_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_ran             = out_ran_r;
  assign out_task_index      = out_idx_r;
  assign out_tick_time       = out_time_r;
  assign out_finished        = out_fin_r;
  assign out_waiting_time    = out_wait_r;
  assign out_turnaround_time = out_turn_r;
  assign out_all_done        = out_done_r;

`ifndef NO_ASSERTIONS
  // A result is only presented once the block has returned to idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // An accepted item keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // Completion is only reported for a tick that served a task.
  a_finish_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> out_ran)
    else $error("finished reported without service");

  // A result without service carries no completion times.
  a_idle_no_times: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ran) |-> (out_waiting_time == '0 && out_turnaround_time == '0))
    else $error("times reported without service");
`endif

endmodule
